/* rtl/eabv_pkg.sv */
// package: types, constants and helpers for the euler angle to basis vector unit
`default_nettype none
package eabv_pkg;
   localparam int CordicIterationsDefault = 16;
   localparam int AtanEntries = 24;
   localparam int AngleWidth = 16;
   localparam int CompWidth = 16;
   localparam int CordicWidth = 34;
   localparam int ZWidth = 32;
   localparam logic signed [CordicWidth-1:0] CordicGain = 34'sd652032874;
   localparam logic signed [AngleWidth+1:0] FullTurn = 18'sd23040;
   localparam logic signed [AngleWidth+1:0] HalfTurn = 18'sd11520;
   localparam logic signed [AngleWidth+1:0] QuarterTurn = 18'sd5760;
   localparam logic signed [CompWidth-1:0] OneQ14 = 16'sd16384;

   typedef logic signed [CompWidth-1:0] comp_type;

   typedef struct packed {
      logic signed [CordicWidth-1:0] x;
      logic signed [CordicWidth-1:0] y;
      logic signed [ZWidth-1:0]      z;
      logic                          neg;
   } cordic_type;

   function automatic logic signed [ZWidth-1:0] atan_entry(input int idx);
      logic signed [ZWidth-1:0] r;
      case (idx)
         0: r = 32'sd188743680;
         1: r = 32'sd111421900;
         2: r = 32'sd58872272;
         3: r = 32'sd29884485;
         4: r = 32'sd15000234;
         5: r = 32'sd7507429;
         6: r = 32'sd3754631;
         7: r = 32'sd1877430;
         8: r = 32'sd938729;
         9: r = 32'sd469366;
         10: r = 32'sd234683;
         11: r = 32'sd117342;
         12: r = 32'sd58671;
         13: r = 32'sd29335;
         14: r = 32'sd14668;
         15: r = 32'sd7334;
         16: r = 32'sd3667;
         17: r = 32'sd1833;
         18: r = 32'sd917;
         19: r = 32'sd458;
         20: r = 32'sd229;
         21: r = 32'sd115;
         22: r = 32'sd57;
         23: r = 32'sd29;
         default: r = '0;
      endcase
      return r;
   endfunction

   // round half up from q30 to q14 and clamp
   function automatic comp_type round_q30(input logic signed [CordicWidth-1:0] v);
      logic signed [CordicWidth-1:0] t;
      logic signed [CordicWidth-17:0] s;
      t = v + 34'sd32768;
      s = t[CordicWidth-1:16];
      if (s > 18'sd16384) return OneQ14;
      if (s < -18'sd16384) return -OneQ14;
      return s[CompWidth-1:0];
   endfunction

   // round half up from q42 to q14 and clamp
   function automatic comp_type round_q42(input logic signed [47:0] v);
      logic signed [47:0] t;
      logic signed [19:0] s;
      t = v + 48'sd134217728;
      s = t[47:28];
      if (s > 20'sd16384) return OneQ14;
      if (s < -20'sd16384) return -OneQ14;
      return s[CompWidth-1:0];
   endfunction
endpackage
`default_nettype wire

/* rtl/eabv_cordic.sv */
// module: angle reduction and pipelined cordic giving sine and cosine
`default_nettype none
module eabv_cordic #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic signed [15:0]       angle,
   output eabv_pkg::comp_type            sin_q14,
   output eabv_pkg::comp_type            cos_q14
);
   import eabv_pkg::*;
   localparam int Steps = (CORDIC_ITERATIONS < AtanEntries) ? CORDIC_ITERATIONS : AtanEntries;

   cordic_type stage_ff [0:Steps];
   cordic_type stage_in [0:Steps];
   comp_type sin_ff, cos_ff;

   always_comb begin
      logic signed [AngleWidth+1:0] a;
      logic neg;
      a = {{2{angle[15]}}, angle};
      while_dummy: begin end
      if (a >= HalfTurn) a = a - FullTurn;
      if (a < -HalfTurn) a = a + FullTurn;
      neg = 1'b0;
      if (a > QuarterTurn) begin
         a = a - HalfTurn;
         neg = 1'b1;
      end else if (a < -QuarterTurn) begin
         a = a + HalfTurn;
         neg = 1'b1;
      end
      stage_in[0].x = CordicGain;
      stage_in[0].y = '0;
      stage_in[0].z = {{(ZWidth-AngleWidth-2){a[AngleWidth+1]}}, a} <<< 16;
      stage_in[0].neg = neg;
   end

   for (genvar i = 0; i < Steps; i++) begin : g_step
      always_comb begin
         logic signed [CordicWidth-1:0] xs, ys;
         xs = stage_ff[i].x >>> i;
         ys = stage_ff[i].y >>> i;
         stage_in[i+1].neg = stage_ff[i].neg;
         if (!stage_ff[i].z[ZWidth-1]) begin
            stage_in[i+1].x = stage_ff[i].x - ys;
            stage_in[i+1].y = stage_ff[i].y + xs;
            stage_in[i+1].z = stage_ff[i].z - atan_entry(i);
         end else begin
            stage_in[i+1].x = stage_ff[i].x + ys;
            stage_in[i+1].y = stage_ff[i].y - xs;
            stage_in[i+1].z = stage_ff[i].z + atan_entry(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i <= Steps; i++) stage_ff[i] <= stage_in[i];
         sin_ff <= round_q30(stage_ff[Steps].neg ? -stage_ff[Steps].y : stage_ff[Steps].y);
         cos_ff <= round_q30(stage_ff[Steps].neg ? -stage_ff[Steps].x : stage_ff[Steps].x);
      end
   end

   assign sin_q14 = sin_ff;
   assign cos_q14 = cos_ff;
endmodule
`default_nettype wire

/* rtl/eabv_combine.sv */
// module: products and sums forming the nine vector components
`default_nettype none
module eabv_combine (
   input  wire logic                clock,
   input  wire logic                en,
   input  wire eabv_pkg::comp_type  sp, cp, sy, cy, sr, cr,
   output logic [143:0]             comps
);
   import eabv_pkg::*;
   logic signed [31:0] spcy_ff, spsy_ff, cpcy_ff, cpsy_ff, crsy_ff, crcy_ff;
   logic signed [31:0] srsy_ff, srcy_ff, srcp_ff, crcp_ff, nsp_ff;
   comp_type sr_ff, cr_ff;
   logic signed [47:0] acc_ff [0:8];
   logic signed [47:0] acc_in [0:8];
   comp_type out_ff [0:8];

   always_comb begin
      acc_in[0] = 48'(cpcy_ff) <<< 14;
      acc_in[1] = 48'(cpsy_ff) <<< 14;
      acc_in[2] = 48'(nsp_ff) <<< 28;
      acc_in[3] = -(48'(sr_ff) * 48'(spcy_ff)) + (48'(crsy_ff) <<< 14);
      acc_in[4] = -(48'(sr_ff) * 48'(spsy_ff)) - (48'(crcy_ff) <<< 14);
      acc_in[5] = -(48'(srcp_ff) <<< 14);
      acc_in[6] = (48'(cr_ff) * 48'(spcy_ff)) + (48'(srsy_ff) <<< 14);
      acc_in[7] = (48'(cr_ff) * 48'(spsy_ff)) - (48'(srcy_ff) <<< 14);
      acc_in[8] = 48'(crcp_ff) <<< 14;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         spcy_ff <= sp * cy;
         spsy_ff <= sp * sy;
         cpcy_ff <= cp * cy;
         cpsy_ff <= cp * sy;
         crsy_ff <= cr * sy;
         crcy_ff <= cr * cy;
         srsy_ff <= sr * sy;
         srcy_ff <= sr * cy;
         srcp_ff <= sr * cp;
         crcp_ff <= cr * cp;
         nsp_ff <= -32'(sp);
         sr_ff <= sr;
         cr_ff <= cr;
         for (int i = 0; i < 9; i++) acc_ff[i] <= acc_in[i];
         for (int i = 0; i < 9; i++) out_ff[i] <= round_q42(acc_ff[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < 9; i++) comps[i*16 +: 16] = out_ff[i];
   end
endmodule
`default_nettype wire

/* rtl/euler_angles_to_basis_vectors_unit.sv */
// top level: euler angles to forward, right and up unit vectors
// stages from req accept to rsp_tvalid: cordic (capped at 24), sin/cos, product, sum, round
// throughput: one item per cycle unless rsp stalls, set by the fully unrolled stages
// the whole pipeline advances whenever the output register is free or being taken
// reset clears the valid bits only; data registers are not reset
`default_nettype none
module euler_angles_to_basis_vectors_unit #(
   parameter int CORDIC_ITERATIONS = eabv_pkg::CordicIterationsDefault
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [47:0]   req_tdata,  // pitch, yaw, roll (signed, 1/64 degree units)
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [143:0]       rsp_tdata   // fwd_x,y,z right_x,y,z up_x,y,z
);
   import eabv_pkg::*;
   localparam int Steps = (CORDIC_ITERATIONS < AtanEntries) ? CORDIC_ITERATIONS : AtanEntries;
   localparam int Depth = Steps + 5;

   logic en;
   logic [Depth-1:0] valid_ff;
   comp_type sp, cp, sy, cy, sr, cr;

   assign en = !valid_ff[Depth-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = valid_ff[Depth-1];

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (en) valid_ff <= {valid_ff[Depth-2:0], req_tvalid};
   end

   eabv_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_pitch (
      .clock(clock), .en(en), .angle(req_tdata[15:0]), .sin_q14(sp), .cos_q14(cp));
   eabv_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_yaw (
      .clock(clock), .en(en), .angle(req_tdata[31:16]), .sin_q14(sy), .cos_q14(cy));
   eabv_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_roll (
      .clock(clock), .en(en), .angle(req_tdata[47:32]), .sin_q14(sr), .cos_q14(cr));

   eabv_combine u_combine (
      .clock(clock), .en(en), .sp(sp), .cp(cp), .sy(sy), .cy(cy), .sr(sr), .cr(cr),
      .comps(rsp_tdata));
endmodule
`default_nettype wire

/* rtl/eabv_checker.sv */
// checker: port level properties of the unit, bound to the top level
`default_nettype none
module eabv_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [143:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)) else $error("rsp hold");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready) else $error("ready while empty");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready) else $error("accept under stall");
   a_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid) else $error("valid after reset");
endmodule

bind euler_angles_to_basis_vectors_unit eabv_checker u_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));
`default_nettype wire
